@@ sv/nps_pkg.sv @@
// Shared types and constants for the nearest path point search.
// Used by the controller, the datapath, the square root unit and the top level.
`default_nettype none

package nps_pkg;

  localparam int IDX_W  = 10;  // point_index / near_index width
  localparam int LEN_W  = 11;  // path_length register width
  localparam int DIFF_W = 34;  // coordinate difference, wide enough for any COORD_BITS up to 32
  localparam int AXIS_W = 20;  // per-axis distance once it is known to be below the limit
  localparam int SQ_W   = 40;  // squared per-axis distance, also holds the limit squared
  localparam int SUM_W  = 42;  // sum of three squares
  localparam int ROOT_W = 20;  // integer square root of a SQ_W value
  localparam int DIST_W = 20;  // distance_mm width

  localparam logic [AXIS_W-1:0] LIMIT_MM = 20'd999000;
  localparam logic [SQ_W-1:0]   LIMIT_SQ = 40'd998001000000;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_wr;
    logic query_start;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic scan_busy;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ sv/nps_in_if.sv @@
// Input channel: load or query transactions with valid/ready handshake.
// Depends on nps_pkg for the index width.
`default_nettype none

interface nps_in_if
  import nps_pkg::*;
#(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [IDX_W-1:0]             point_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, mode, point_index, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

@@ sv/nps_out_if.sv @@
// Result channel: nearest point transactions with valid/ready handshake.
// Depends on nps_pkg for the index and distance widths.
`default_nettype none

interface nps_out_if
  import nps_pkg::*;
#(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] near_x;
  logic signed [COORD_BITS-1:0] near_y;
  logic signed [COORD_BITS-1:0] near_z;
  logic [IDX_W-1:0]             near_index;
  logic [DIST_W-1:0]            distance_mm;
  logic                         found;

  modport source (output valid, near_x, near_y, near_z, near_index, distance_mm, found,
                  input ready);
  modport sink   (input valid, near_x, near_y, near_z, near_index, distance_mm, found,
                  output ready);
endinterface

`default_nettype wire

@@ sv/nps_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on nps_pkg for SQ_W and ROOT_W.
`default_nettype none

module nps_sqrt
  import nps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign rem_sh = {rem, rad[SQ_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("sqrt did not begin on start");
  assert property (@(posedge clk) disable iff (rst) !(busy && done))
    else $error("sqrt busy and done together");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("sqrt step count ran out while busy");

endmodule

`default_nettype wire

@@ sv/nps_dp.sv @@
// Datapath: point table memory, scan pipeline, best tracking, result register.
// Depends on nps_pkg, nps_in_if, nps_out_if and nps_sqrt.
`default_nettype none

module nps_dp
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  input  wire cmd_t             cmd,
  output status_t               status,
  nps_in_if.sink                req,
  nps_out_if.source             rsp
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = ($clog2(MAX_POINTS + 1) > LEN_W) ? $clog2(MAX_POINTS + 1) : LEN_W;

  typedef logic [2:0][COORD_BITS-1:0] point_t;

  logic [LEN_W-1:0] path_length;

  point_t           mem [MAX_POINTS];
  point_t           wr_pt;
  logic             wr_in_range;

  // scan control
  point_t           q_pt;
  logic             issuing;
  logic [CW-1:0]    rd_cnt;
  logic [CW-1:0]    n_scan;
  logic [CW-1:0]    n_next;

  // pipeline stages
  logic             s1_valid, s2_valid, s3_valid, s4_valid;
  logic [AW-1:0]    s1_idx, s2_idx, s3_idx, s4_idx;
  point_t           s1_pt, s2_pt, s3_pt, s4_pt;
  logic             s2_ok, s3_ok, s4_ok;
  logic [2:0][AXIS_W-1:0] s2_d;
  logic [2:0][SQ_W-1:0]   s3_sq;
  logic [SUM_W-1:0] s4_sum;

  logic [2:0][DIFF_W-1:0] diff;
  logic [2:0][DIFF_W-1:0] mag;
  logic [2:0]             axis_ok;

  // best so far
  logic             best_found;
  logic [SQ_W-1:0]  best_sq;
  logic [AW-1:0]    best_idx;
  point_t           best_pt;

  logic             root_done;
  logic [ROOT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length <= '0;
    end else if (cfg_wr_en) begin
      path_length <= cfg_wr_data;
    end
  end

  assign wr_pt[0]    = req.coord_x;
  assign wr_pt[1]    = req.coord_y;
  assign wr_pt[2]    = req.coord_z;
  assign wr_in_range = 32'(req.point_index) < MAX_POINTS;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_in_range) begin
      mem[AW'(req.point_index)] <= wr_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      s1_pt <= mem[rd_cnt[AW-1:0]];
    end
  end

  assign n_next = (32'(path_length) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(path_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
    end else if (cmd.query_start) begin
      issuing <= n_next != '0;
    end else if (issuing && (rd_cnt + 1'b1 == n_scan)) begin
      issuing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_pt   <= wr_pt;
      rd_cnt <= '0;
      n_scan <= n_next;
    end else if (issuing) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]    = DIFF_W'(signed'(s1_pt[a])) - DIFF_W'(signed'(q_pt[a]));
      mag[a]     = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : diff[a];
      axis_ok[a] = mag[a] < DIFF_W'(LIMIT_MM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= issuing;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_cnt[AW-1:0];
    s2_idx <= s1_idx;
    s2_pt  <= s1_pt;
    s2_ok  <= &axis_ok;
    for (int a = 0; a < 3; a++) begin
      s2_d[a]  <= mag[a][AXIS_W-1:0];
      s3_sq[a] <= SQ_W'(s2_d[a]) * SQ_W'(s2_d[a]);
    end
    s3_idx <= s2_idx;
    s3_pt  <= s2_pt;
    s3_ok  <= s2_ok;
    s4_idx <= s3_idx;
    s4_pt  <= s3_pt;
    s4_ok  <= s3_ok;
    s4_sum <= SUM_W'(s3_sq[0]) + SUM_W'(s3_sq[1]) + SUM_W'(s3_sq[2]);
  end

  // keep the first strictly smaller distance
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.query_start) begin
      best_found <= 1'b0;
    end else if (s4_valid && s4_ok && (s4_sum < SUM_W'(best_sq))) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      best_sq <= LIMIT_SQ;
    end else if (s4_valid && s4_ok && (s4_sum < SUM_W'(best_sq))) begin
      best_sq  <= SQ_W'(s4_sum);
      best_idx <= s4_idx;
      best_pt  <= s4_pt;
    end
  end

  nps_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (best_sq),
    .done     (root_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.found <= best_found;
      if (best_found) begin
        rsp.near_x      <= best_pt[0];
        rsp.near_y      <= best_pt[1];
        rsp.near_z      <= best_pt[2];
        rsp.near_index  <= IDX_W'(best_idx);
        rsp.distance_mm <= DIST_W'(root);
      end else begin
        rsp.near_x      <= '0;
        rsp.near_y      <= '0;
        rsp.near_z      <= '0;
        rsp.near_index  <= '0;
        rsp.distance_mm <= '0;
      end
    end
  end

  assign req.ready = cmd.in_ready;

  assign status.in_valid  = req.valid;
  assign status.in_mode   = req.mode;
  assign status.scan_busy = issuing | s1_valid | s2_valid | s3_valid | s4_valid;
  assign status.root_done = root_done;
  assign status.out_free  = !rsp.valid || rsp.ready;

  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid && !rsp.found |-> rsp.distance_mm == '0 && rsp.near_index == '0)
    else $error("empty result carries nonzero fields");
  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid && rsp.found |-> rsp.distance_mm < DIST_W'(LIMIT_MM))
    else $error("reported distance not below limit");
  assert property (@(posedge clk) disable iff (rst) best_found |-> best_sq < LIMIT_SQ)
    else $error("best distance not below limit");

endmodule

`default_nettype wire

@@ sv/nps_ctrl.sv @@
// Controller: sequences load, scan, square root and result hand-off.
// Depends on nps_pkg for state, command and status types.
`default_nettype none

module nps_ctrl
  import nps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          if (status.in_mode == MODE_QUERY) begin
            cmd.query_start = 1'b1;
            state_next      = ST_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // wait for the last point to leave the pipeline
        if (!status.scan_busy) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status.root_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending transaction");
  assert property (@(posedge clk) disable iff (rst) cmd.sqrt_start |-> !status.scan_busy)
    else $error("square root started during scan");
  assert property (@(posedge clk) disable iff (rst) cmd.query_start |=> !cmd.in_ready)
    else $error("input taken while a query is in flight");

endmodule

`default_nettype wire

@@ sv/nearest_path_point_search.sv @@
// Channel  Dir  Handshake          Payload
// req      in   valid/ready        mode, point_index, coord_x, coord_y, coord_z
// rsp      out  valid/ready        near_x, near_y, near_z, near_index, distance_mm, found
// cfg      in   cfg_wr_en          cfg_wr_data -> path_length
//
// A load transaction is written to the table as it is accepted, and the next
// transaction is accepted right after. A query reads min(path_length, MAX_POINTS)
// table entries, one table read per cycle, lets the distance pipeline drain, starts
// the square root, waits for its result and hands it to rsp; an empty path reads none.
// Reset clears control and path_length; the table is undefined until loaded and needs
// no clearing pass. A stalled rsp holds its transaction while the next request is
// already accepted and worked on; a second result waits and blocks req until rsp drains.
`default_nettype none

module nearest_path_point_search
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  nps_in_if.sink                req,
  nps_out_if.source             rsp
);

  cmd_t    cmd;
  status_t status;

  nps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  nps_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .req         (req),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
